// ----- rtl/q2e_pkg.sv -----
// Shared types, widths and the arctangent table for the quaternion to Euler angle block.
`default_nettype none
package q2e_pkg;

  localparam int unsigned TERM_W    = 34;
  localparam int unsigned CORD_W    = 38;
  localparam int unsigned ANG_W     = 34;
  localparam int unsigned SQ_OP_W   = 58;
  localparam int unsigned SQ_RES_W  = 29;
  localparam int unsigned SQ_STAGES = 29;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned TAB_LEN   = 24;

  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
  localparam logic signed [ANG_W-1:0]  DEG90_Q24 = ANG_W'(64'sd1509949440);

  typedef enum logic [3:0] {
    ORD_XYX = 4'd0,
    ORD_XZX = 4'd1,
    ORD_YXY = 4'd2,
    ORD_YZY = 4'd3,
    ORD_ZXZ = 4'd4,
    ORD_ZYZ = 4'd5,
    ORD_XYZ = 4'd6,
    ORD_XZY = 4'd7,
    ORD_YXZ = 4'd8,
    ORD_YZX = 4'd9,
    ORD_ZXY = 4'd10,
    ORD_ZYX = 4'd11
  } axis_order_e;

  typedef struct packed {
    logic signed [TERM_W-1:0] mid;
    logic signed [TERM_W-1:0] sa;
    logic signed [TERM_W-1:0] ca;
    logic signed [TERM_W-1:0] sc;
    logic signed [TERM_W-1:0] cc;
    logic                     proper;
    logic                     bad;
  } term_t;

  function automatic logic signed [ANG_W-1:0] atan_deg(input int unsigned i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:       v = ANG_W'(64'sd754974720);
      1:       v = ANG_W'(64'sd445687602);
      2:       v = ANG_W'(64'sd235489088);
      3:       v = ANG_W'(64'sd119537938);
      4:       v = ANG_W'(64'sd60000934);
      5:       v = ANG_W'(64'sd30029717);
      6:       v = ANG_W'(64'sd15018523);
      7:       v = ANG_W'(64'sd7509720);
      8:       v = ANG_W'(64'sd3754917);
      9:       v = ANG_W'(64'sd1877466);
      10:      v = ANG_W'(64'sd938734);
      11:      v = ANG_W'(64'sd469367);
      12:      v = ANG_W'(64'sd234684);
      13:      v = ANG_W'(64'sd117342);
      14:      v = ANG_W'(64'sd58671);
      15:      v = ANG_W'(64'sd29335);
      16:      v = ANG_W'(64'sd14668);
      17:      v = ANG_W'(64'sd7334);
      18:      v = ANG_W'(64'sd3667);
      19:      v = ANG_W'(64'sd1833);
      20:      v = ANG_W'(64'sd917);
      21:      v = ANG_W'(64'sd458);
      22:      v = ANG_W'(64'sd229);
      23:      v = ANG_W'(64'sd115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_to_euler_angles_top.sv -----
// Top level: quaternion to Euler angles for twelve axis sequences.
//
//   channel | handshake                  | payload
//   input   | in_valid_i / in_ready_o    | quat_w_i, quat_x_i, quat_y_i, quat_z_i, axis_order_i
//   output  | out_valid_o / out_ready_i  | angle_first_o, angle_middle_o, angle_third_o
//
// One word per cycle in and out while the output is not stalled. The path runs through the
// front registers, the queue, the setup registers, 29 square root stages, CORDIC_STEPS + 1
// CORDIC stages and one output register. Reset clears all valid flags and the queue; no sweep.
// A stalled output holds the whole back end; the queue absorbs the front.
`default_nettype none
module quaternion_to_euler_angles_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [3:0]         axis_order_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      angle_first_o,
  output logic signed [15:0]      angle_middle_o,
  output logic signed [15:0]      angle_third_o
);

  localparam int unsigned TW = q2e_pkg::TERM_W;
  localparam int unsigned AW = q2e_pkg::ANG_W;
  localparam int unsigned OW = q2e_pkg::SQ_OP_W;
  localparam int unsigned RW = AW + 1;
  localparam int unsigned SH = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] LIM  = RW'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] SMAX = RW'(32767);
  localparam logic signed [RW-1:0] SMIN = -RW'(32768);
  localparam logic signed [OW-1:0] ONE_SQ = OW'(1) <<< 56;

  q2e_pkg::term_t f_term, q_term, a_term_q, a_term_d, b_term_q, s_side;
  logic           f_valid, f_ready, q_valid, q_ready;
  logic           en, a_v_q, b_v_q, s_valid;
  logic signed [29:0]    a_mid_q;
  logic signed [OW-1:0]  mid_sq;
  logic [OW-1:0]         b_op_q;
  logic [q2e_pkg::SQ_RES_W-1:0] s_res;
  logic signed [TW-1:0]  s_ext, m_y, m_x;
  logic                  c1_v, c2_v, c3_v, c1_t, c2_t, c3_t;
  logic signed [AW-1:0]  c1_a, c2_a, c3_a;
  logic                  out_v_q;
  logic signed [15:0]    af_q, am_q, at_q;

  function automatic logic signed [15:0] to_field(input logic signed [AW-1:0] a);
    logic signed [RW-1:0] s;
    logic signed [RW-1:0] q;
    s = RW'(a) + HALF;
    q = s >>> SH;
    if (q > LIM) q = LIM;
    if (q < -LIM) q = -LIM;
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    return q[15:0];
  endfunction

  q2e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quat_w_i     (quat_w_i),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .axis_order_i (axis_order_i),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .term_o       (f_term),
    .term_valid_o (f_valid),
    .term_ready_i (f_ready)
  );

  q2e_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (f_term),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .rd_data_o  (q_term),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready)
  );

  assign en      = !out_v_q || out_ready_i;
  assign q_ready = en;

  // clamp the middle term, then square it
  always_comb begin
    a_term_d = q_term;
    if (q_term.mid > q2e_pkg::ONE_Q28) begin
      a_term_d.mid = q2e_pkg::ONE_Q28;
    end else if (q_term.mid < -q2e_pkg::ONE_Q28) begin
      a_term_d.mid = -q2e_pkg::ONE_Q28;
    end
  end

  assign mid_sq = a_mid_q * a_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= q_valid;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_term_q <= a_term_d;
      a_mid_q  <= a_term_d.mid[29:0];
      b_term_q <= a_term_q;
      b_op_q   <= OW'(ONE_SQ - mid_sq);
    end
  end

  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .op_i    (b_op_q),
    .side_i  (b_term_q),
    .valid_o (s_valid),
    .res_o   (s_res),
    .side_o  (s_side)
  );

  assign s_ext = TW'(s_res);
  assign m_y   = s_side.proper ? s_ext : s_side.mid;
  assign m_x   = s_side.proper ? s_side.mid : s_ext;

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cord_first (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .valid_i (s_valid), .tag_i (s_side.bad),
    .y_i (s_side.sa), .x_i (s_side.ca),
    .valid_o (c1_v), .tag_o (c1_t), .ang_o (c1_a)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cord_mid (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .valid_i (s_valid), .tag_i (s_side.bad),
    .y_i (m_y), .x_i (m_x),
    .valid_o (c2_v), .tag_o (c2_t), .ang_o (c2_a)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cord_third (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .valid_i (s_valid), .tag_i (s_side.bad),
    .y_i (s_side.sc), .x_i (s_side.cc),
    .valid_o (c3_v), .tag_o (c3_t), .ang_o (c3_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= c1_v & c2_v & c3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (c1_t | c2_t | c3_t) begin
        af_q <= '0;
        am_q <= '0;
        at_q <= '0;
      end else begin
        af_q <= to_field(c1_a);
        am_q <= to_field(c2_a);
        at_q <= to_field(c3_a);
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign angle_first_o  = af_q;
  assign angle_middle_o = am_q;
  assign angle_third_o  = at_q;

endmodule
`default_nettype wire

// ----- rtl/q2e_front.sv -----
// Front end: accepts quaternion words, forms products and selects the five terms per sequence.
`default_nettype none
module q2e_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [15:0]  quat_w_i,
  input  wire logic signed [15:0]  quat_x_i,
  input  wire logic signed [15:0]  quat_y_i,
  input  wire logic signed [15:0]  quat_z_i,
  input  wire logic [3:0]          axis_order_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  output q2e_pkg::term_t           term_o,
  output logic                     term_valid_o,
  input  wire logic                term_ready_i
);

  localparam int unsigned TW = q2e_pkg::TERM_W;

  typedef struct packed {
    logic signed [31:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  } prod_t;

  logic           en;
  logic           s1_v_q, s2_v_q;
  prod_t          p_q, p_d;
  logic [3:0]     code_q;
  q2e_pkg::term_t term_q, term_d;

  function automatic logic signed [TW-1:0] add2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [TW-1:0] s;
    s = TW'(a) + TW'(b);
    return s <<< 1;
  endfunction

  function automatic logic signed [TW-1:0] sub2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [TW-1:0] s;
    s = TW'(a) - TW'(b);
    return s <<< 1;
  endfunction

  assign en           = !s2_v_q || term_ready_i;
  assign ready_o      = en;
  assign term_valid_o = s2_v_q;
  assign term_o       = term_q;

  always_comb begin
    p_d.ww = quat_w_i * quat_w_i;
    p_d.xx = quat_x_i * quat_x_i;
    p_d.yy = quat_y_i * quat_y_i;
    p_d.zz = quat_z_i * quat_z_i;
    p_d.wx = quat_w_i * quat_x_i;
    p_d.wy = quat_w_i * quat_y_i;
    p_d.wz = quat_w_i * quat_z_i;
    p_d.xy = quat_x_i * quat_y_i;
    p_d.xz = quat_x_i * quat_z_i;
    p_d.yz = quat_y_i * quat_z_i;
  end

  always_comb begin
    logic signed [TW-1:0] cx, cy, cz;
    cx = add2(p_q.ww, p_q.xx) - q2e_pkg::ONE_Q28;
    cy = add2(p_q.ww, p_q.yy) - q2e_pkg::ONE_Q28;
    cz = add2(p_q.ww, p_q.zz) - q2e_pkg::ONE_Q28;
    term_d        = '0;
    term_d.proper = 1'b0;
    term_d.bad    = 1'b0;
    case (q2e_pkg::axis_order_e'(code_q))
      q2e_pkg::ORD_XYX: begin
        term_d.mid = cx; term_d.sa = add2(p_q.wz, p_q.xy); term_d.ca = sub2(p_q.wy, p_q.xz);
        term_d.sc = sub2(p_q.xy, p_q.wz); term_d.cc = add2(p_q.wy, p_q.xz);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_XZX: begin
        term_d.mid = cx; term_d.sa = sub2(p_q.xz, p_q.wy); term_d.ca = add2(p_q.wz, p_q.xy);
        term_d.sc = add2(p_q.wy, p_q.xz); term_d.cc = sub2(p_q.wz, p_q.xy);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_YXY: begin
        term_d.mid = cy; term_d.sa = sub2(p_q.xy, p_q.wz); term_d.ca = add2(p_q.wx, p_q.yz);
        term_d.sc = add2(p_q.wz, p_q.xy); term_d.cc = sub2(p_q.wx, p_q.yz);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_YZY: begin
        term_d.mid = cy; term_d.sa = add2(p_q.wx, p_q.yz); term_d.ca = sub2(p_q.wz, p_q.xy);
        term_d.sc = sub2(p_q.yz, p_q.wx); term_d.cc = add2(p_q.wz, p_q.xy);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_ZXZ: begin
        term_d.mid = cz; term_d.sa = add2(p_q.wy, p_q.xz); term_d.ca = sub2(p_q.wx, p_q.yz);
        term_d.sc = sub2(p_q.xz, p_q.wy); term_d.cc = add2(p_q.wx, p_q.yz);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_ZYZ: begin
        term_d.mid = cz; term_d.sa = sub2(p_q.yz, p_q.wx); term_d.ca = add2(p_q.wy, p_q.xz);
        term_d.sc = add2(p_q.wx, p_q.yz); term_d.cc = sub2(p_q.wy, p_q.xz);
        term_d.proper = 1'b1;
      end
      q2e_pkg::ORD_XYZ: begin
        term_d.mid = add2(p_q.wy, p_q.xz); term_d.sa = sub2(p_q.wx, p_q.yz); term_d.ca = cz;
        term_d.sc = sub2(p_q.wz, p_q.xy); term_d.cc = cx;
      end
      q2e_pkg::ORD_XZY: begin
        term_d.mid = sub2(p_q.wz, p_q.xy); term_d.sa = add2(p_q.wx, p_q.yz); term_d.ca = cy;
        term_d.sc = add2(p_q.wy, p_q.xz); term_d.cc = cx;
      end
      q2e_pkg::ORD_YXZ: begin
        term_d.mid = sub2(p_q.wx, p_q.yz); term_d.sa = add2(p_q.wy, p_q.xz); term_d.ca = cz;
        term_d.sc = add2(p_q.wz, p_q.xy); term_d.cc = cy;
      end
      q2e_pkg::ORD_YZX: begin
        term_d.mid = add2(p_q.wz, p_q.xy); term_d.sa = sub2(p_q.wy, p_q.xz); term_d.ca = cx;
        term_d.sc = sub2(p_q.wx, p_q.yz); term_d.cc = cy;
      end
      q2e_pkg::ORD_ZXY: begin
        term_d.mid = add2(p_q.wx, p_q.yz); term_d.sa = sub2(p_q.wz, p_q.xy); term_d.ca = cy;
        term_d.sc = sub2(p_q.wy, p_q.xz); term_d.cc = cz;
      end
      q2e_pkg::ORD_ZYX: begin
        term_d.mid = sub2(p_q.wy, p_q.xz); term_d.sa = add2(p_q.wz, p_q.xy); term_d.ca = cx;
        term_d.sc = add2(p_q.wx, p_q.yz); term_d.cc = cz;
      end
      default: begin
        term_d.bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q    <= p_d;
      code_q <= axis_order_i;
      term_q <= term_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/q2e_fifo.sv -----
// Short register queue of term words between the front and back ends.
`default_nettype none
module q2e_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  q2e_pkg::term_t      wr_data_i,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  output q2e_pkg::term_t      rd_data_o,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i
);

  localparam int unsigned DEPTH = q2e_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  q2e_pkg::term_t mem_q [DEPTH];
  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/q2e_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side word carried along.
`default_nettype none
module q2e_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [q2e_pkg::SQ_OP_W-1:0]       op_i,
  input  q2e_pkg::term_t                         side_i,
  output logic                                   valid_o,
  output logic [q2e_pkg::SQ_RES_W-1:0]           res_o,
  output q2e_pkg::term_t                         side_o
);

  localparam int unsigned N  = q2e_pkg::SQ_STAGES;
  localparam int unsigned OW = q2e_pkg::SQ_OP_W;

  logic [OW-1:0]  op_q  [N];
  logic [OW-1:0]  res_q [N];
  logic           v_q   [N];
  q2e_pkg::term_t side_q[N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned K = N - 1 - j;
    logic [OW-1:0]  op_c, res_c, tmp, bitv, op_n, res_n;
    logic           v_c;
    q2e_pkg::term_t side_c;
    if (j == 0) begin : g_first
      assign op_c   = op_i;
      assign res_c  = '0;
      assign v_c    = valid_i;
      assign side_c = side_i;
    end else begin : g_next
      assign op_c   = op_q[j-1];
      assign res_c  = res_q[j-1];
      assign v_c    = v_q[j-1];
      assign side_c = side_q[j-1];
    end
    assign bitv = OW'(1) << (2 * K);
    assign tmp  = res_c + bitv;
    always_comb begin
      if (op_c >= tmp) begin
        op_n  = op_c - tmp;
        res_n = (res_c >> 1) + bitv;
      end else begin
        op_n  = op_c;
        res_n = res_c >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[j]   <= op_n;
        res_q[j]  <= res_n;
        side_q[j] <= side_c;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign res_o   = res_q[N-1][q2e_pkg::SQ_RES_W-1:0];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

// ----- rtl/q2e_cordic.sv -----
// Pipelined CORDIC vectoring unit giving atan2 in Q.24 degrees.
`default_nettype none
module q2e_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic                               tag_i,
  input  wire logic signed [q2e_pkg::TERM_W-1:0]  y_i,
  input  wire logic signed [q2e_pkg::TERM_W-1:0]  x_i,
  output logic                                    valid_o,
  output logic                                    tag_o,
  output logic signed [q2e_pkg::ANG_W-1:0]        ang_o
);

  localparam int unsigned CW = q2e_pkg::CORD_W;
  localparam int unsigned AW = q2e_pkg::ANG_W;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [AW-1:0] a_q [STEPS+1];
  logic                 v_q [STEPS+1];
  logic                 t_q [STEPS+1];
  logic                 z_q [STEPS+1];

  logic signed [CW-1:0] x0, y0, xe, ye;
  logic signed [AW-1:0] a0;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  always_comb begin
    x0 = xe;
    y0 = ye;
    a0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        a0 = q2e_pkg::DEG90_Q24;
      end else begin
        x0 = -ye;
        y0 = xe;
        a0 = -q2e_pkg::DEG90_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      a_q[0] <= a0;
      t_q[0] <= tag_i;
      z_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys;
    logic signed [AW-1:0] ti;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign ti = q2e_pkg::atan_deg(i);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          a_q[i+1] <= a_q[i] + ti;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          a_q[i+1] <= a_q[i] - ti;
        end
        t_q[i+1] <= t_q[i];
        z_q[i+1] <= z_q[i];
      end
    end
  end

  assign valid_o = v_q[STEPS];
  assign tag_o   = t_q[STEPS];
  assign ang_o   = z_q[STEPS] ? '0 : a_q[STEPS];

endmodule
`default_nettype wire
